### design/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

	localparam int DEFAULT_CAPACITY = 16;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;

	// operation codes carried on kind
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_DEQUEUED = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// one stored entry
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic signed [DATA_W-1:0] data;
	} entry_t;

endpackage

### design/spq_mem.sv
// Entry store: one write port, one read port, registered read data.
module spq_mem #(
	parameter int DEPTH = spq_pkg::DEFAULT_CAPACITY,
	parameter int AW    = $clog2(spq_pkg::DEFAULT_CAPACITY)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  spq_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output spq_pkg::entry_t rdata
);

	spq_pkg::entry_t mem [DEPTH];
	spq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/stable_priority_queue_top.sv
// Stable min-first priority queue: sequencer around a circular sorted entry store.
//
// Usage
//   Command channel: an item (kind, item_data, item_priority) is taken at a rising
//   edge with start high and busy low. kind 0 enqueues, kind 1 dequeues.
//   Result channel: every item gives one result (status, out_data, out_priority),
//   shown for exactly one cycle with done high. The receiver cannot stall it.
//   busy falls in the same cycle that done rises, so the next item may be issued
//   while the result is on the ports.
// Storage
//   Entries sit in one RAM, sorted by priority in circular order starting at the
//   head pointer. A dequeue reads the head and bumps the pointer. An enqueue walks
//   back from the tail one entry per cycle, moving each entry of larger priority
//   up one slot, and drops the new entry behind the first one that is not larger,
//   so equal priorities keep arrival order.
// Sequence (acceptance to done)
//   From S_IDLE alone: enqueue when full or empty, dequeue when empty.
//   Dequeue: S_IDLE, then S_DQ. Other enqueues: S_CMP per entry compared, back
//   from the tail to the first that is not larger; S_PUT if all are larger.
//   The walk is set by the single RAM read port, one entry per cycle.
// Reset
//   arst_n clears the count and pointers; RAM contents need no clearing.
module stable_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               kind,
	input  logic signed [spq_pkg::DATA_W-1:0] item_data,
	input  logic signed [spq_pkg::PRIO_W-1:0] item_priority,
	output logic                               done,
	output logic        [1:0]                  status,
	output logic signed [spq_pkg::DATA_W-1:0] out_data,
	output logic signed [spq_pkg::PRIO_W-1:0] out_priority
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PUT,
		S_DQ
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   left_q;
	spq_pkg::entry_t new_q;
	logic            done_q;
	logic [1:0]      status_q;
	logic signed [spq_pkg::DATA_W-1:0] out_data_q;
	logic signed [spq_pkg::PRIO_W-1:0] out_prio_q;

	logic            accept;
	logic            is_empty;
	logic            is_full;
	logic [AW:0]     tail_sum;
	logic [AW-1:0]   tail_ptr;
	logic            larger;
	spq_pkg::entry_t in_entry;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	spq_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	spq_pkg::entry_t mem_rdata;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		if (p == AW'(CAPACITY - 1)) begin
			return '0;
		end
		return p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		if (p == '0) begin
			return AW'(CAPACITY - 1);
		end
		return p - AW'(1);
	endfunction

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(CAPACITY));

	assign in_entry = {item_priority, item_data};

	// physical slot of the last entry; only used when the queue is not empty
	assign tail_sum = {1'b0, head_q} + (AW + 1)'(count_q) - (AW + 1)'(1);
	assign tail_ptr = (tail_sum >= (AW + 1)'(CAPACITY))
		? AW'(tail_sum - (AW + 1)'(CAPACITY)) : tail_sum[AW-1:0];

	// entry just read sorts behind the new one
	assign larger = (mem_rdata.prio > new_q.prio);

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = new_q;
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == spq_pkg::OP_DEQ) begin
						mem_re    = !is_empty;
						mem_raddr = head_q;
					end else if (!is_full) begin
						if (is_empty) begin
							mem_we    = 1'b1;
							mem_waddr = head_q;
							mem_wdata = in_entry;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = tail_ptr;
						end
					end
				end
			end
			S_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_inc(rd_ptr_q);
				if (larger) begin
					mem_wdata = mem_rdata;
					mem_re    = (left_q != CW'(1));
					mem_raddr = ptr_dec(rd_ptr_q);
				end else begin
					mem_wdata = new_q;
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = rd_ptr_q;
				mem_wdata = new_q;
			end
			S_DQ: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	spq_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			left_q     <= '0;
			new_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= spq_pkg::ST_ENQUEUED;
			out_data_q <= '0;
			out_prio_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q      <= in_entry;
						out_data_q <= '0;
						out_prio_q <= '0;
						if (kind == spq_pkg::OP_DEQ) begin
							if (is_empty) begin
								done_q   <= 1'b1;
								status_q <= spq_pkg::ST_EMPTY;
							end else begin
								state_q <= S_DQ;
							end
						end else if (is_full) begin
							done_q   <= 1'b1;
							status_q <= spq_pkg::ST_FULL;
						end else if (is_empty) begin
							done_q   <= 1'b1;
							status_q <= spq_pkg::ST_ENQUEUED;
							count_q  <= count_q + CW'(1);
						end else begin
							rd_ptr_q <= tail_ptr;
							left_q   <= count_q;
							state_q  <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (larger) begin
						if (left_q == CW'(1)) begin
							// everything stored is larger: new entry goes to the front
							state_q <= S_PUT;
						end else begin
							rd_ptr_q <= ptr_dec(rd_ptr_q);
							left_q   <= left_q - CW'(1);
						end
					end else begin
						done_q   <= 1'b1;
						status_q <= spq_pkg::ST_ENQUEUED;
						count_q  <= count_q + CW'(1);
						state_q  <= S_IDLE;
					end
				end
				S_PUT: begin
					done_q   <= 1'b1;
					status_q <= spq_pkg::ST_ENQUEUED;
					count_q  <= count_q + CW'(1);
					state_q  <= S_IDLE;
				end
				S_DQ: begin
					done_q     <= 1'b1;
					status_q   <= spq_pkg::ST_DEQUEUED;
					out_data_q <= mem_rdata.data;
					out_prio_q <= mem_rdata.prio;
					head_q     <= ptr_inc(head_q);
					count_q    <= count_q - CW'(1);
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("read and write hit the same slot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == spq_pkg::ST_DEQUEUED))
			|-> ((count_q + CW'(1)) == $past(count_q)))
		else $error("dequeue did not drop the count by one");

endmodule
